// ===== hdl/sum_pkg.sv =====
// Shared types and constants of the supply undervoltage monitor.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package sum_pkg;

   typedef logic [15:0]        level_type;
   typedef logic signed [16:0] dev_type;
   typedef logic [31:0]        var_type;
   typedef logic [7:0]         count_type;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_HOLD_RELOAD    = 2'd2,
      CSR_SLOW_PERIOD    = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_ACK  = 1'b1
   } cmd_type;

   localparam level_type LowThresholdReset  = 16'd29000;
   localparam level_type HighThresholdReset = 16'd33000;
   localparam count_type HoldReloadReset    = 8'd7;
   localparam count_type SlowPeriodReset    = 8'd200;
   localparam count_type HoldCountReset     = 8'd5;

   typedef struct packed {
      level_type low_threshold;
      level_type high_threshold;
      count_type hold_reload;
      count_type slow_period;
   } cfg_type;

   typedef struct packed {
      logic      is_tick;
      level_type mean_level;
      dev_type   deviation;
      level_type magnitude;
      logic      supply_lost;
      logic      ack_waiting;
   } mid_type;

endpackage

// ===== hdl/sum_if.sv =====
// Valid/ready channel interfaces for the request and response words of the monitor.
// Depends on sum_pkg for the field types.
interface sum_req_if import sum_pkg::*;;
   logic      valid;
   logic      ready;
   logic      cmd;
   level_type sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface sum_rsp_if import sum_pkg::*;;
   logic      valid;
   logic      ready;
   level_type mean_level;
   dev_type   deviation;
   var_type   variance_level;
   logic      supply_lost;
   logic      ack_waiting;

   modport source (output valid, output mean_level, output deviation, output variance_level,
                   output supply_lost, output ack_waiting, input ready);
   modport sink (input valid, input mean_level, input deviation, input variance_level,
                 input supply_lost, input ack_waiting, output ready);
endinterface

// ===== hdl/sum_csr_regs.sv =====
// Configuration registers of the monitor: thresholds, hold-off reload and slow period.
// Depends on sum_pkg.
module sum_csr_regs import sum_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_THRESHOLD:  cfg_in.low_threshold  = csr_wdata;
            CSR_HIGH_THRESHOLD: cfg_in.high_threshold = csr_wdata;
            CSR_HOLD_RELOAD:    cfg_in.hold_reload    = csr_wdata[7:0];
            CSR_SLOW_PERIOD:    cfg_in.slow_period    = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= LowThresholdReset;
         cfg_ff.high_threshold <= HighThresholdReset;
         cfg_ff.hold_reload    <= HoldReloadReset;
         cfg_ff.slow_period    <= SlowPeriodReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/sum_level_stage.sv =====
// Input register and first stage: mean update, deviation, thresholds, hold-off and flags.
// Depends on sum_pkg and sum_req_if.
module sum_level_stage import sum_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   sum_req_if.sink req_chan,
   output logic    mid_valid,
   input  logic    mid_ready,
   output mid_type mid_word
);

   logic      in_valid_ff, in_valid_in;
   logic      in_cmd_ff;
   level_type in_sample_ff;
   logic      mid_valid_ff, mid_valid_in;
   mid_type   mid_ff, mid_in;
   level_type mean_ff, mean_in;
   count_type tick_ff, tick_in;
   count_type hold_ff, hold_in;
   logic      lost_ff, lost_in;
   logic      ack_ff, ack_in;

   logic      mid_free;
   logic      fire;
   logic      is_tick;
   logic [19:0] mean_sum;
   level_type mean_new;
   dev_type   dev_tick;
   level_type mag;
   logic      low_hit;
   count_type hold_low;
   count_type tick_inc;
   logic      period_hit;
   logic      can_clear;

   assign mid_free       = !mid_valid_ff || mid_ready;
   assign fire           = in_valid_ff && mid_free;
   assign req_chan.ready = !in_valid_ff || mid_free;
   assign is_tick        = (in_cmd_ff == CMD_TICK);

   always_comb begin
      mean_sum   = {mean_ff, 4'b0000} - {4'b0000, mean_ff} + {4'b0000, in_sample_ff};
      mean_new   = mean_sum[19:4];
      dev_tick   = $signed({1'b0, in_sample_ff} - {1'b0, mean_new});
      mag        = (in_sample_ff >= mean_new) ? (in_sample_ff - mean_new)
                                              : (mean_new - in_sample_ff);
      low_hit    = (in_sample_ff < cfg.low_threshold);
      hold_low   = low_hit ? cfg.hold_reload : hold_ff;
      tick_inc   = tick_ff + 8'd1;
      period_hit = (tick_inc == cfg.slow_period);
      can_clear  = period_hit && (hold_low == 8'd0)
                   && (in_sample_ff > cfg.high_threshold) && ack_ff;

      mean_in = mean_ff;
      tick_in = tick_ff;
      hold_in = hold_ff;
      lost_in = lost_ff;
      ack_in  = ack_ff;
      if (fire) begin
         if (!is_tick) begin
            ack_in = 1'b1;
         end else begin
            mean_in = mean_new;
            tick_in = period_hit ? 8'd0 : tick_inc;
            hold_in = (period_hit && (hold_low != 8'd0)) ? (hold_low - 8'd1) : hold_low;
            lost_in = (lost_ff || low_hit) && !can_clear;
            ack_in  = ack_ff && !can_clear;
         end
      end

      mid_in.is_tick     = is_tick;
      mid_in.mean_level  = mean_in;
      mid_in.deviation   = is_tick ? dev_tick : '0;
      mid_in.magnitude   = mag;
      mid_in.supply_lost = lost_in;
      mid_in.ack_waiting = ack_in;

      in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
      mid_valid_in = mid_free ? in_valid_ff : mid_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         mean_ff      <= '0;
         tick_ff      <= '0;
         hold_ff      <= HoldCountReset;
         lost_ff      <= 1'b0;
         ack_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         mean_ff      <= mean_in;
         tick_ff      <= tick_in;
         hold_ff      <= hold_in;
         lost_ff      <= lost_in;
         ack_ff       <= ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_cmd_ff    <= req_chan.cmd;
         in_sample_ff <= req_chan.sample;
      end
      if (fire) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_word  = mid_ff;

endmodule

// ===== hdl/sum_var_stage.sv =====
// Second stage and result register: squared deviation and exponential variance update.
// Depends on sum_pkg and sum_rsp_if.
module sum_var_stage import sum_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      mid_valid,
   output logic      mid_ready,
   input  mid_type   mid_word,
   sum_rsp_if.source rsp_chan
);

   logic        rsp_valid_ff, rsp_valid_in;
   var_type     var_ff, var_in;
   level_type   out_mean_ff;
   dev_type     out_dev_ff;
   var_type     out_var_ff;
   logic        out_lost_ff;
   logic        out_ack_ff;

   logic        load;
   var_type     sq;
   logic [35:0] var_sum;

   assign mid_ready = !rsp_valid_ff || rsp_chan.ready;
   assign load      = mid_valid && mid_ready;

   always_comb begin
      sq           = {16'b0, mid_word.magnitude} * {16'b0, mid_word.magnitude};
      var_sum      = {var_ff, 4'b0000} - {4'b0000, var_ff} + {4'b0000, sq};
      var_in       = (load && mid_word.is_tick) ? var_sum[35:4] : var_ff;
      rsp_valid_in = mid_ready ? mid_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         var_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         var_ff       <= var_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_mean_ff <= mid_word.mean_level;
         out_dev_ff  <= mid_word.deviation;
         out_var_ff  <= var_in;
         out_lost_ff <= mid_word.supply_lost;
         out_ack_ff  <= mid_word.ack_waiting;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.mean_level     = out_mean_ff;
   assign rsp_chan.deviation      = out_dev_ff;
   assign rsp_chan.variance_level = out_var_ff;
   assign rsp_chan.supply_lost    = out_lost_ff;
   assign rsp_chan.ack_waiting    = out_ack_ff;

endmodule

// ===== hdl/supply_undervoltage_monitor_top.sv =====
// Top level of the supply undervoltage monitor: configuration registers and two pipeline stages.
// Depends on sum_pkg, sum_if, sum_csr_regs, sum_level_stage and sum_var_stage.

// The monitor takes one word per clock cycle unless the response side stalls, and returns one
// result word for each through the input, middle and result registers. The rate is set by the
// two state loops: the mean, hold-off and flag registers update once per cycle in the first
// stage, and the variance register with its 16 by 16 squarer updates once per cycle in the
// second. A stalled response holds the result register while earlier stages keep filling,
// so up to three words may be in flight. No clearing pass is needed after reset.
module supply_undervoltage_monitor_top import sum_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   sum_req_if.sink                  req_chan,
   sum_rsp_if.source                rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type cfg;
   logic    mid_valid;
   logic    mid_ready;
   mid_type mid_word;

   sum_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sum_level_stage u_level_stage (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_word  (mid_word)
   );

   sum_var_stage u_var_stage (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_word  (mid_word),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (mid_valid && rsp_chan.valid && !rsp_chan.ready))
      else $error("request side stalled while the pipeline has room");

   a_mid_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (mid_valid && !mid_ready) |=> (mid_valid && $stable(mid_word)))
      else $error("middle stage word changed while stalled");

   a_ack_has_no_deviation: assert property (@(posedge clock) disable iff (reset)
      (mid_valid && !mid_word.is_tick) |-> (mid_word.deviation == '0 && mid_word.ack_waiting))
      else $error("acknowledge word carries a deviation or no pending acknowledge");
`endif

endmodule

// ===== bench/supply_undervoltage_monitor_top_tb.sv =====
// Self-checking bench for supply_undervoltage_monitor_top: directed rows, then random phases.
// Depends on sum_pkg and the channel interfaces in sum_if; predicts each result word a row does not give.
module supply_undervoltage_monitor_top_tb;
   import sum_pkg::*;

   localparam int ClockHalf    = 5;
   localparam int PipeLatency  = 3;
   localparam int CycleLimit   = 400000;
   localparam int RandomPhases = 12;
   localparam int PhaseWords   = 138;

   typedef struct packed {
      level_type mean_level;
      dev_type   deviation;
      var_type   variance_level;
      logic      supply_lost;
      logic      ack_waiting;
   } monitor_word_type;

   typedef enum logic {
      ROW_WORD,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type     kind;
      cmd_type          cmd;
      level_type        sample;
      csr_index_type    index;
      logic [15:0]      value;
      bit               typed;
      monitor_word_type want;
   } stim_row_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   sum_req_if req_chan ();
   sum_rsp_if rsp_chan ();

   supply_undervoltage_monitor_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   level_type low_cfg;
   level_type high_cfg;
   count_type reload_cfg;
   count_type period_cfg;

   level_type mean_state;
   var_type   var_state;
   count_type tick_state;
   count_type hold_state;
   logic      lost_state;
   logic      ack_state;

   monitor_word_type pending_words[$];
   stim_row_type     stim_table[$];
   idle_mode_type    idle_mode;
   int               error_count;
   int               word_count;
   int               checked_count;
   int               ack_count;
   int               recover_count;
   int               setting_count;
   int               cycle_count;

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("Timed out after %0d cycles with %0d words outstanding.", cycle_count,
               pending_words.size());
      $display("supply_undervoltage_monitor_top_tb: errors");
      $finish;
   end

   function automatic monitor_word_type advance_monitor(cmd_type cmd, level_type sample);
      monitor_word_type word;
      int unsigned      mixed;
      int unsigned      mag;
      longint unsigned  spread;
      logic [16:0]      dev_bits;
      dev_bits = '0;
      if (cmd == CMD_ACK) begin
         ack_state = 1'b1;
         ack_count++;
      end else begin
         mixed = (32'(mean_state) * 15 + 32'(sample)) >> 4;
         mean_state = level_type'(mixed);
         if (32'(sample) >= mixed) begin
            mag = 32'(sample) - mixed;
            dev_bits = 17'(mag);
         end else begin
            mag = mixed - 32'(sample);
            dev_bits = 17'(0) - 17'(mag);
         end
         spread = (64'(var_state) * 15 + 64'(mag) * 64'(mag)) >> 4;
         var_state = var_type'(spread);
         if (sample < low_cfg) begin
            lost_state = 1'b1;
            hold_state = reload_cfg;
         end
         tick_state = tick_state + 8'd1;
         if (tick_state == period_cfg) begin
            tick_state = '0;
            if (hold_state != '0) begin
               hold_state = hold_state - 8'd1;
            end else if (sample > high_cfg && ack_state) begin
               ack_state = 1'b0;
               lost_state = 1'b0;
               recover_count++;
            end
         end
      end
      word.mean_level     = mean_state;
      word.deviation      = dev_type'(dev_bits);
      word.variance_level = var_state;
      word.supply_lost    = lost_state;
      word.ack_waiting    = ack_state;
      return word;
   endfunction

   function automatic stim_row_type word_row(cmd_type cmd, level_type sample);
      stim_row_type row;
      row.kind   = ROW_WORD;
      row.cmd    = cmd;
      row.sample = sample;
      row.index  = CSR_LOW_THRESHOLD;
      row.value  = '0;
      row.typed  = 1'b0;
      row.want   = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(cmd_type cmd, level_type sample, level_type mean,
                                              dev_type dev, var_type spread, logic lost,
                                              logic ack);
      stim_row_type row;
      row = word_row(cmd, sample);
      row.typed = 1'b1;
      row.want  = '{mean, dev, spread, lost, ack};
      return row;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type index, logic [15:0] value);
      stim_row_type row;
      row = word_row(CMD_TICK, '0);
      row.kind  = ROW_CSR;
      row.index = index;
      row.value = value;
      return row;
   endfunction

   task automatic add_row(stim_row_type row);
      stim_table.insert(stim_table.size(), row);
   endtask

   function automatic int sender_idle_pct();
      return (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 19 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (idle_mode == IDLE_RECEIVER) ? 47 : (idle_mode == IDLE_BOTH) ? 19 : 0;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is accepted.
   task automatic send_word(cmd_type cmd, level_type sample, bit typed, monitor_word_type want);
      monitor_word_type predicted;
      if (csr_wr_en) csr_wr_en <= 1'b0;
      if ($urandom_range(99) < sender_idle_pct()) begin
         req_chan.valid  <= 1'b0;
         req_chan.cmd    <= 1'($urandom);
         req_chan.sample <= level_type'($urandom);
         @(negedge clock);
         while ($urandom_range(99) < sender_idle_pct()) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.cmd    <= cmd;
      req_chan.sample <= sample;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      predicted = advance_monitor(cmd, sample);
      pending_words.insert(pending_words.size(), typed ? want : predicted);
      word_count++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      if (csr_wr_en) csr_wr_en <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (PipeLatency + 5) @(posedge clock);
      @(negedge clock);
   endtask

   // Called at a falling edge while the block is idle; the caller lowers the write enable.
   task automatic write_register(csr_index_type index, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_LOW_THRESHOLD:  low_cfg = value;
         CSR_HIGH_THRESHOLD: high_cfg = value;
         CSR_HOLD_RELOAD:    reload_cfg = value[7:0];
         CSR_SLOW_PERIOD:    period_cfg = value[7:0];
         default: ;
      endcase
      setting_count++;
      @(negedge clock);
   endtask

   function automatic level_type clip_level(int value);
      return (value < 0) ? 16'd0 : (value > 65535) ? 16'hFFFF : level_type'(value);
   endfunction

   function automatic level_type pick_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      if (pick < 40) return level_type'($urandom);
      if (pick < 70) return clip_level(int'(low_cfg) + $urandom_range(127) - 64);
      return clip_level(int'(high_cfg) + $urandom_range(2000) - 100);
   endfunction

   task automatic random_setting();
      int          pick;
      logic [15:0] low_value;
      logic [15:0] high_value;
      logic [7:0]  reload_value;
      logic [7:0]  period_value;
      pick = $urandom_range(9);
      low_value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                  (pick < 6) ? 16'($urandom) : 16'($urandom_range(34000, 24000));
      pick = $urandom_range(9);
      high_value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                   (pick < 4) ? 16'($urandom) :
                   clip_level(int'(low_value) + $urandom_range(8000));
      pick = $urandom_range(9);
      reload_value = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                     (pick < 8) ? 8'($urandom_range(3)) : 8'($urandom);
      pick = $urandom_range(9);
      period_value = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                     (pick < 8) ? 8'($urandom_range(6, 1)) : 8'($urandom);
      settle();
      write_register(CSR_LOW_THRESHOLD, low_value);
      write_register(CSR_HIGH_THRESHOLD, high_value);
      write_register(CSR_HOLD_RELOAD, {8'd0, reload_value});
      write_register(CSR_SLOW_PERIOD, {8'd0, period_value});
   endtask

   always @(posedge clock) begin
      monitor_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         checked_count++;
         if (pending_words.size() == 0) begin
            $display("%0t: result word with no expectation: mean %0d dev %0d var %0d", $time,
                     rsp_chan.mean_level, rsp_chan.deviation, rsp_chan.variance_level);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_chan.mean_level !== want.mean_level) begin
               $display("%0t: mean_level expected %0d, got %0d", $time, want.mean_level,
                        rsp_chan.mean_level);
               error_count++;
            end
            if (rsp_chan.deviation !== want.deviation) begin
               $display("%0t: deviation expected %0d, got %0d", $time, want.deviation,
                        rsp_chan.deviation);
               error_count++;
            end
            if (rsp_chan.variance_level !== want.variance_level) begin
               $display("%0t: variance_level expected %0d, got %0d", $time,
                        want.variance_level, rsp_chan.variance_level);
               error_count++;
            end
            if (rsp_chan.supply_lost !== want.supply_lost) begin
               $display("%0t: supply_lost expected %0b, got %0b", $time, want.supply_lost,
                        rsp_chan.supply_lost);
               error_count++;
            end
            if (rsp_chan.ack_waiting !== want.ack_waiting) begin
               $display("%0t: ack_waiting expected %0b, got %0b", $time, want.ack_waiting,
                        rsp_chan.ack_waiting);
               error_count++;
            end
         end
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_LOW_THRESHOLD;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.cmd    = CMD_TICK;
      req_chan.sample = '0;
      idle_mode       = IDLE_NONE;
      cycle_count     = 0;
      error_count     = 0;
      word_count      = 0;
      checked_count   = 0;
      ack_count       = 0;
      recover_count   = 0;
      setting_count   = 0;
      low_cfg    = LowThresholdReset;
      high_cfg   = HighThresholdReset;
      reload_cfg = HoldReloadReset;
      period_cfg = SlowPeriodReset;
      mean_state = '0;
      var_state  = '0;
      tick_state = '0;
      hold_state = HoldCountReset;
      lost_state = 1'b0;
      ack_state  = 1'b0;

      // The first rows run on the reset settings; later rows write new periods, hold-off reloads and
      // thresholds between words, with samples at and around the new thresholds.
      add_row(known_row(CMD_ACK, 16'd0, 16'd0, 17'sd0, 32'd0, 1'b0, 1'b1));
      add_row(known_row(CMD_TICK, 16'd0, 16'd0, 17'sd0, 32'd0, 1'b1, 1'b1));
      add_row(known_row(CMD_TICK, 16'hFFFF, 16'd4095, 17'sd61440, 32'd235929600,
                        1'b1, 1'b1));
      add_row(word_row(CMD_TICK, 16'hFFFF));
      add_row(word_row(CMD_ACK, 16'hFFFF));
      add_row(word_row(CMD_TICK, 16'd0));
      add_row(csr_row(CSR_SLOW_PERIOD, 16'd1));
      add_row(csr_row(CSR_HOLD_RELOAD, 16'd0));
      add_row(csr_row(CSR_LOW_THRESHOLD, 16'd100));
      add_row(csr_row(CSR_HIGH_THRESHOLD, 16'd60000));
      add_row(word_row(CMD_TICK, 16'd50));
      add_row(word_row(CMD_TICK, 16'hFFFF));
      add_row(word_row(CMD_TICK, 16'hFFFF));
      add_row(word_row(CMD_TICK, 16'd0));
      add_row(word_row(CMD_TICK, 16'hFFFF));
      add_row(word_row(CMD_ACK, 16'd12345));
      add_row(word_row(CMD_TICK, 16'd60000));
      add_row(word_row(CMD_TICK, 16'd60001));
      add_row(csr_row(CSR_SLOW_PERIOD, 16'd2));
      add_row(csr_row(CSR_HOLD_RELOAD, 16'd255));
      add_row(csr_row(CSR_LOW_THRESHOLD, 16'hFFFF));
      add_row(csr_row(CSR_HIGH_THRESHOLD, 16'hFFFE));
      add_row(word_row(CMD_TICK, 16'hFFFF));
      add_row(word_row(CMD_TICK, 16'hFFFE));
      add_row(word_row(CMD_TICK, 16'hFFFF));
      add_row(csr_row(CSR_SLOW_PERIOD, 16'd0));
      add_row(csr_row(CSR_LOW_THRESHOLD, 16'd0));
      add_row(csr_row(CSR_HIGH_THRESHOLD, 16'd0));
      add_row(word_row(CMD_TICK, 16'd0));
      add_row(word_row(CMD_TICK, 16'd1));
      add_row(word_row(CMD_ACK, 16'hAAAA));
      add_row(word_row(CMD_TICK, 16'h5555));

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            settle();
            write_register(stim_table[i].index, stim_table[i].value);
         end else begin
            send_word(stim_table[i].cmd, stim_table[i].sample, stim_table[i].typed,
                      stim_table[i].want);
         end
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         random_setting();
         idle_mode = idle_mode_type'(phase % 4);
         for (int n = 0; n < PhaseWords; n++) begin
            if ($urandom_range(99) < 10) begin
               send_word(CMD_ACK, level_type'($urandom), 1'b0, '0);
            end else begin
               send_word(CMD_TICK, pick_sample(), 1'b0, '0);
            end
         end
      end

      settle();
      idle_mode = IDLE_NONE;
      repeat (2 * PipeLatency + 4) @(posedge clock);
      if (pending_words.size() != 0) begin
         $display("%0d expected words never arrived.", pending_words.size());
         error_count++;
      end
      $display("Sent %0d words (%0d acknowledges) across %0d register writes and four idle",
               word_count, ack_count, setting_count);
      $display("patterns; checked %0d results, saw %0d acknowledged recoveries.",
               checked_count, recover_count);
      if (error_count == 0) begin
         $display("supply_undervoltage_monitor_top_tb: clean");
      end else begin
         $display("supply_undervoltage_monitor_top_tb: errors");
      end
      $finish;
   end

endmodule
